### hw/rtl/msrd_pkg.sv
`default_nettype none
package msrd_pkg;

  // Fraction bits of the internal normalised format
  localparam int unsigned QN = 30;
  // Default depth of the request queue between front and back
  localparam int unsigned DefQueueDepth = 2;

  typedef struct packed {
    logic signed [31:0] m_c0_r0;
    logic signed [31:0] m_c0_r1;
    logic signed [31:0] m_c0_r2;
    logic signed [31:0] m_c1_r0;
    logic signed [31:0] m_c1_r1;
    logic signed [31:0] m_c1_r2;
    logic signed [31:0] m_c2_r0;
    logic signed [31:0] m_c2_r1;
    logic signed [31:0] m_c2_r2;
  } in_req_t;

  typedef struct packed {
    logic        [31:0] scale_x;
    logic        [31:0] scale_y;
    logic        [31:0] scale_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               degenerate;
  } out_res_t;

  // Classified request: magnitude and sign of each entry, index column*3+row
  typedef struct packed {
    logic [8:0][31:0] mag;
    logic [8:0]       neg;
  } entry_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQ,
    B_SC_WAIT,
    B_NORM_GO,
    B_NORM_WAIT,
    B_TRACE,
    B_ROOT_WAIT,
    B_QDIV_GO,
    B_QDIV_WAIT,
    B_OUT
  } back_state_e;

  // Quaternion component carried by the square root
  typedef enum logic [1:0] {
    AXIS_W,
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // Round a Q.30 magnitude to Q2.14, ties away from zero, and saturate
  function automatic logic [15:0] to_q14(logic [31:0] mag, logic neg, logic big);
    logic [32:0] sum;
    logic [16:0] r;
    sum = {1'b0, mag} + 33'h0_0000_8000;
    r   = sum[32:16];
    if (neg) begin
      to_q14 = (big || (r > 17'd32768)) ? 16'h8000 : 16'(17'd0 - r);
    end else begin
      to_q14 = (big || (r > 17'd32767)) ? 16'h7fff : r[15:0];
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/msrd_in_if.sv
`default_nettype none
interface msrd_in_if;
  import msrd_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface
`default_nettype wire

### hw/rtl/msrd_out_if.sv
`default_nettype none
interface msrd_out_if;
  import msrd_pkg::*;
  logic     valid;
  logic     ready;
  out_res_t res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface
`default_nettype wire

### hw/rtl/matrix_scale_rotation_decompose.sv
// Channel   Dir  Payload                                    Handshake
// in_i      in   m_c0_r0 .. m_c2_r2, signed Q16.16           valid/ready
// out_o     out  scale_x/y/z Q16.16, quat_w..z Q2.14, degen  valid/ready
//
// Per matrix, per column: the entries are squared on one 32x32 multiplier
// and summed, and the sum waits on the shared root unit (32 steps); nine
// normalising and three quaternion quotients run on the shared divider
// (31 steps), and the quaternion root again on the shared root unit; the
// back also pops the request, picks the case and loads the output register.
// Requests queue in front (QueueDepth deep) while the back works or its
// output register waits, so in_i stalls only when the queue is full.
// Reset is asynchronous, active low, and empties queue and output register.
`default_nettype none
module matrix_scale_rotation_decompose #(
  parameter int unsigned QueueDepth = msrd_pkg::DefQueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  msrd_in_if.sink   in_i,
  msrd_out_if.source out_o
);
  import msrd_pkg::*;

  entry_t head;
  logic   head_valid;
  logic   pop;

  // front: takes requests, splits sign and magnitude, queues them
  msrd_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  // back: column norms, normalisation, four-case quaternion, output register
  msrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

### hw/rtl/msrd_front.sv
`default_nettype none
module msrd_front #(
  parameter int unsigned QueueDepth = msrd_pkg::DefQueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  msrd_in_if.sink               in_i,
  output msrd_pkg::entry_t      head_o,
  output logic                  head_valid_o,
  input  wire logic             pop_i
);
  import msrd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            queue_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic [8:0][31:0]  raw;
  entry_t            cls;
  logic              push;

  assign raw[0] = in_i.req.m_c0_r0;
  assign raw[1] = in_i.req.m_c0_r1;
  assign raw[2] = in_i.req.m_c0_r2;
  assign raw[3] = in_i.req.m_c1_r0;
  assign raw[4] = in_i.req.m_c1_r1;
  assign raw[5] = in_i.req.m_c1_r2;
  assign raw[6] = in_i.req.m_c2_r0;
  assign raw[7] = in_i.req.m_c2_r1;
  assign raw[8] = in_i.req.m_c2_r2;

  // sign and magnitude split; -2^31 gives magnitude 2^31
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      cls.neg[i] = raw[i][31];
      cls.mag[i] = raw[i][31] ? (32'd0 - raw[i]) : raw[i];
    end
  end

  assign in_i.ready   = (cnt_q != CntW'(QueueDepth));
  assign push         = in_i.valid && in_i.ready;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/msrd_sqrt.sv
`default_nettype none
module msrd_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] v_i,
  output logic             done_o,
  output logic [31:0]      root_o
);
  import msrd_pkg::*;

  // one result bit per cycle, restoring
  logic [63:0] v_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] rem_sh, trial;

  assign rem_sh = {rem_q[33:0], v_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= v_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      v_q <= {v_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/msrd_div.sv
`default_nettype none
module msrd_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [30:0]      quo_o,
  output logic             ovf_o
);
  import msrd_pkg::*;

  // 31 quotient bits, one per cycle; ovf when the quotient needs more
  logic [33:0] rem_q;
  logic [30:0] lo_q, quo_q;
  logic [32:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q, ovf_q;
  logic [33:0] rem_sh;

  assign rem_sh = {rem_q[32:0], lo_q[30]};
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd30) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[63:31]};
      lo_q  <= num_i[30:0];
      den_q <= den_i;
      quo_q <= '0;
      ovf_q <= (num_i[63:31] >= den_i);
    end else if (busy_q) begin
      lo_q <= {lo_q[29:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[29:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[29:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/msrd_back.sv
`default_nettype none
module msrd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire msrd_pkg::entry_t head_i,
  input  wire logic             head_valid_i,
  output logic                  pop_o,
  msrd_out_if.source            out_o
);
  import msrd_pkg::*;

  localparam logic signed [33:0] One = 34'sd1073741824;

  back_state_e        state_q, state_d;
  entry_t             ent_q, ent_d;
  logic [1:0]         col_q, col_d, k_q, k_d, j_q, j_d;
  logic [63:0]        prod_q, prod_d, acc_q, acc_d;
  logic [31:0]        sc_q [3];
  logic [31:0]        sc_d [3];
  logic signed [31:0] n_q [9];
  logic signed [31:0] n_d [9];
  logic signed [32:0] num_q [3];
  logic signed [32:0] num_d [3];
  logic [15:0]        qv_q [3];
  logic [15:0]        qv_d [3];
  logic [15:0]        ax_q, ax_d;
  logic [32:0]        s_q, s_d;
  axis_e              axis_q, axis_d;
  logic               degen_q, degen_d, qneg_q, qneg_d;
  logic               out_valid_q, out_valid_d;
  out_res_t           out_q, out_d;

  logic [3:0]         idx;
  logic [31:0]        mag_sel;
  logic               sqrt_start, sqrt_done, div_start, div_done, div_ovf;
  logic [63:0]        sqrt_v, div_num;
  logic [32:0]        div_den;
  logic [31:0]        root;
  logic [30:0]        quo;
  logic signed [33:0] tr, rad;
  logic [32:0]        rad_c;
  logic signed [32:0] num_sel;
  logic [32:0]        num_mag;
  logic               out_free;

  assign idx     = 4'(col_q) * 4'd3 + 4'(k_q);
  assign mag_sel = (idx < 4'd9) ? ent_q.mag[idx] : '0;
  assign prod_d  = (state_q == B_SQ) ? 64'(mag_sel) * 64'(mag_sel) : prod_q;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.res   = out_q;

  msrd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     (sqrt_v),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  msrd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo),
    .ovf_o   (div_ovf)
  );

  always_comb begin
    tr      = 34'(n_q[0]) + 34'(n_q[4]) + 34'(n_q[8]);
    num_sel = (j_q == 2'd0) ? num_q[0] : ((j_q == 2'd1) ? num_q[1] : num_q[2]);
    num_mag = num_sel[32] ? 33'(-num_sel) : 33'(num_sel);
  end

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    col_d       = col_q;
    k_d         = k_q;
    j_d         = j_q;
    acc_d       = acc_q;
    sc_d        = sc_q;
    n_d         = n_q;
    num_d       = num_q;
    qv_d        = qv_q;
    ax_d        = ax_q;
    s_d         = s_q;
    axis_d      = axis_q;
    degen_d     = degen_q;
    qneg_d      = qneg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    pop_o       = 1'b0;
    sqrt_start  = 1'b0;
    sqrt_v      = acc_q + prod_q;
    div_start   = 1'b0;
    div_num     = {2'b00, mag_sel, 30'd0};
    div_den     = {1'b0, sc_q[col_q]};
    rad         = tr + One;
    rad_c       = '0;

    unique case (state_q)
      B_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          ent_d   = head_i;
          col_d   = '0;
          k_d     = '0;
          state_d = B_SQ;
        end
      end
      B_SQ: begin
        // square of entry k registered, added to the sum in the next cycle
        acc_d = (k_q == 2'd0) ? '0 : acc_q + prod_q;
        if (k_q == 2'd3) begin
          sqrt_start = 1'b1;
          state_d    = B_SC_WAIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      B_SC_WAIT: begin
        if (sqrt_done) begin
          sc_d[col_q] = root;
          k_d         = '0;
          if (col_q == 2'd2) begin
            col_d = '0;
            if ((sc_q[0] == '0) || (sc_q[1] == '0) || (root == '0)) begin
              degen_d = 1'b1;
              axis_d  = AXIS_W;
              ax_d    = '0;
              qv_d    = '{default: '0};
              state_d = B_OUT;
            end else begin
              degen_d = 1'b0;
              state_d = B_NORM_GO;
            end
          end else begin
            col_d   = col_q + 1'b1;
            state_d = B_SQ;
          end
        end
      end
      B_NORM_GO: begin
        div_start = 1'b1;
        state_d   = B_NORM_WAIT;
      end
      B_NORM_WAIT: begin
        if (div_done) begin
          n_d[idx] = ent_q.neg[idx] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
          state_d  = B_NORM_GO;
          if (k_q == 2'd2) begin
            k_d = '0;
            if (col_q == 2'd2) begin
              state_d = B_TRACE;
            end else begin
              col_d = col_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      B_TRACE: begin
        priority if (tr > 34'sd0) begin
          axis_d   = AXIS_W;
          rad      = tr + One;
          num_d[0] = 33'(n_q[5]) - 33'(n_q[7]);
          num_d[1] = 33'(n_q[6]) - 33'(n_q[2]);
          num_d[2] = 33'(n_q[1]) - 33'(n_q[3]);
        end else if ((n_q[0] > n_q[4]) && (n_q[0] > n_q[8])) begin
          axis_d   = AXIS_X;
          rad      = One + 34'(n_q[0]) - 34'(n_q[4]) - 34'(n_q[8]);
          num_d[0] = 33'(n_q[5]) - 33'(n_q[7]);
          num_d[1] = 33'(n_q[1]) + 33'(n_q[3]);
          num_d[2] = 33'(n_q[6]) + 33'(n_q[2]);
        end else if (n_q[4] > n_q[8]) begin
          axis_d   = AXIS_Y;
          rad      = One + 34'(n_q[4]) - 34'(n_q[0]) - 34'(n_q[8]);
          num_d[0] = 33'(n_q[6]) - 33'(n_q[2]);
          num_d[1] = 33'(n_q[1]) + 33'(n_q[3]);
          num_d[2] = 33'(n_q[5]) + 33'(n_q[7]);
        end else begin
          axis_d   = AXIS_Z;
          rad      = One + 34'(n_q[8]) - 34'(n_q[0]) - 34'(n_q[4]);
          num_d[0] = 33'(n_q[1]) - 33'(n_q[3]);
          num_d[1] = 33'(n_q[6]) + 33'(n_q[2]);
          num_d[2] = 33'(n_q[5]) + 33'(n_q[7]);
        end
        rad_c      = rad[33] ? '0 : rad[32:0];
        sqrt_v     = {1'b0, rad_c, 30'd0};
        sqrt_start = 1'b1;
        state_d    = B_ROOT_WAIT;
      end
      B_ROOT_WAIT: begin
        if (sqrt_done) begin
          s_d     = {root, 1'b0};
          ax_d    = to_q14({1'b0, root[31:1]}, 1'b0, 1'b0);
          j_d     = '0;
          state_d = B_QDIV_GO;
        end
      end
      B_QDIV_GO: begin
        div_num   = {1'b0, num_mag, 30'd0};
        div_den   = s_q;
        qneg_d    = num_sel[32];
        div_start = 1'b1;
        state_d   = B_QDIV_WAIT;
      end
      B_QDIV_WAIT: begin
        if (div_done) begin
          qv_d[j_q] = (s_q == '0) ? '0 : to_q14({1'b0, quo}, qneg_q, div_ovf);
          if (j_q == 2'd2) begin
            state_d = B_OUT;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = B_QDIV_GO;
          end
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.scale_x      = sc_q[0];
          out_d.scale_y      = sc_q[1];
          out_d.scale_z      = sc_q[2];
          out_d.degenerate   = degen_q;
          unique case (axis_q)
            AXIS_W: begin
              out_d.quat_w = ax_q;
              out_d.quat_x = qv_q[0];
              out_d.quat_y = qv_q[1];
              out_d.quat_z = qv_q[2];
            end
            AXIS_X: begin
              out_d.quat_w = qv_q[0];
              out_d.quat_x = ax_q;
              out_d.quat_y = qv_q[1];
              out_d.quat_z = qv_q[2];
            end
            AXIS_Y: begin
              out_d.quat_w = qv_q[0];
              out_d.quat_x = qv_q[1];
              out_d.quat_y = ax_q;
              out_d.quat_z = qv_q[2];
            end
            AXIS_Z: begin
              out_d.quat_w = qv_q[0];
              out_d.quat_x = qv_q[1];
              out_d.quat_y = qv_q[2];
              out_d.quat_z = ax_q;
            end
            default: begin
              out_d.quat_w = '0;
              out_d.quat_x = '0;
              out_d.quat_y = '0;
              out_d.quat_z = '0;
            end
          endcase
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    col_q   <= col_d;
    k_q     <= k_d;
    j_q     <= j_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    sc_q    <= sc_d;
    n_q     <= n_d;
    num_q   <= num_d;
    qv_q    <= qv_d;
    ax_q    <= ax_d;
    s_q     <= s_d;
    axis_q  <= axis_d;
    degen_q <= degen_d;
    qneg_q  <= qneg_d;
    out_q   <= out_d;
  end

endmodule
`default_nettype wire

### hw/rtl/msrd_checker.sv
`default_nettype none
module msrd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire msrd_pkg::out_res_t res_i
);
  import msrd_pkg::*;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid straight after reset");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && res_i.degenerate) |->
      (res_i.quat_w == '0 && res_i.quat_x == '0 && res_i.quat_y == '0 &&
       res_i.quat_z == '0))
    else $error("degenerate result with non-zero quaternion");

  a_degen_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (res_i.degenerate ==
      (res_i.scale_x == '0 || res_i.scale_y == '0 || res_i.scale_z == '0)))
    else $error("degenerate flag disagrees with scales");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(res_i)))
    else $error("stalled result changed");

endmodule

bind matrix_scale_rotation_decompose msrd_checker u_msrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .res_i       (out_o.res)
);
`default_nettype wire
